FILE: sv/mqcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the MQTT control packet parser: phase codes, status and type codes,
// the summary result type and the phase helper functions. No dependencies.
package mqcp_pkg;

	typedef enum logic [23:0] {
		PH_FIRST    = 24'h000001,
		PH_LEN      = 24'h000002,
		PH_CN_NLHI  = 24'h000004,
		PH_CN_NLLO  = 24'h000008,
		PH_CN_NAME  = 24'h000010,
		PH_CN_LEVEL = 24'h000020,
		PH_CN_FLAGS = 24'h000040,
		PH_CN_KAHI  = 24'h000080,
		PH_CN_KALO  = 24'h000100,
		PH_DONE     = 24'h000200,
		PH_BAD      = 24'h000400,
		PH_CA_B0    = 24'h000800,
		PH_CA_B1    = 24'h001000,
		PH_PB_TLHI  = 24'h002000,
		PH_PB_TLLO  = 24'h004000,
		PH_PB_TOPIC = 24'h008000,
		PH_PB_IDHI  = 24'h010000,
		PH_PB_IDLO  = 24'h020000,
		PH_SB_IDHI  = 24'h040000,
		PH_SB_IDLO  = 24'h080000,
		PH_SB_FLHI  = 24'h100000,
		PH_SB_FLLO  = 24'h200000,
		PH_SB_FILT  = 24'h400000,
		PH_SB_OPTS  = 24'h800000
	} phase_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MORE = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	localparam logic [3:0] TYPE_CONNECT   = 4'd1;
	localparam logic [3:0] TYPE_CONNACK   = 4'd2;
	localparam logic [3:0] TYPE_PUBLISH   = 4'd3;
	localparam logic [3:0] TYPE_SUBSCRIBE = 4'd8;

	localparam logic [28:0] OFFSET_MAX = 29'h1FFF_FFFF;
	localparam logic [7:0]  COUNT_MAX  = 8'hFF;
	localparam logic [1:0]  LEN_LAST   = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  packet_type;
		logic [3:0]  header_flags;
		logic [27:0] rem_length;
		logic [15:0] packet_ident;
		logic [15:0] keepalive_secs;
		logic [7:0]  connect_flags;
		logic [7:0]  protocol_level;
		logic [7:0]  connack_code;
		logic        sess_present;
		logic [15:0] topic_length;
		logic [7:0]  filter_count;
	} result_t;

	function automatic phase_t start_phase(input logic [3:0] ptype);
		phase_t ph;
		case (ptype)
			TYPE_CONNECT: ph = PH_CN_NLHI;
			TYPE_CONNACK: ph = PH_CA_B0;
			TYPE_PUBLISH: ph = PH_PB_TLHI;
			TYPE_SUBSCRIBE: ph = PH_SB_IDHI;
			default: ph = PH_DONE;
		endcase
		return ph;
	endfunction

	function automatic logic [1:0] status_of(input phase_t ph);
		logic [1:0] st;
		case (ph)
			PH_DONE: st = ST_OK;
			PH_BAD: st = ST_BAD;
			PH_CN_NLHI, PH_CN_NLLO, PH_CN_NAME, PH_CN_LEVEL,
			PH_CN_FLAGS, PH_CN_KAHI, PH_CN_KALO: st = ST_MORE;
			PH_CA_B0, PH_CA_B1: st = ST_MORE;
			PH_PB_TLHI, PH_PB_TLLO, PH_PB_TOPIC: st = ST_BAD;
			PH_PB_IDHI, PH_PB_IDLO, PH_SB_IDHI, PH_SB_IDLO: st = ST_MORE;
			default: st = ST_OK;
		endcase
		return st;
	endfunction

endpackage
`default_nettype wire

FILE: sv/mqcp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Byte request channel of the MQTT control packet parser: valid, ready and one
// buffer byte with its end mark. No dependencies.
interface mqcp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       buffer_end;

	modport source (output valid, output data_byte, output buffer_end, input ready);
	modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface
`default_nettype wire

FILE: sv/mqcp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Summary request channel of the MQTT control packet parser: valid, ready and
// the decoded header fields. No dependencies.
interface mqcp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  packet_type;
	logic [3:0]  header_flags;
	logic [27:0] rem_length;
	logic [15:0] packet_ident;
	logic [15:0] keepalive_secs;
	logic [7:0]  connect_flags;
	logic [7:0]  protocol_level;
	logic [7:0]  connack_code;
	logic        sess_present;
	logic [15:0] topic_length;
	logic [7:0]  filter_count;

	modport source (output valid, output status, output packet_type, output header_flags,
		output rem_length, output packet_ident, output keepalive_secs,
		output connect_flags, output protocol_level, output connack_code,
		output sess_present, output topic_length, output filter_count, input ready);
	modport sink (input valid, input status, input packet_type, input header_flags,
		input rem_length, input packet_ident, input keepalive_secs,
		input connect_flags, input protocol_level, input connack_code,
		input sess_present, input topic_length, input filter_count, output ready);
endinterface
`default_nettype wire

FILE: sv/mqcp_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-entry output buffer for summary requests: an output register and a skid register.
// Depends on mqcp_pkg and mqcp_out_if.
module mqcp_skid (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire mqcp_pkg::result_t push_data,
	output logic                  space,
	mqcp_out_if.source            res
);
	import mqcp_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    out_free;

	assign out_free = !out_valid_q || res.ready;
	assign space = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign res.valid = out_valid_q;
	assign res.status = out_q.status;
	assign res.packet_type = out_q.packet_type;
	assign res.header_flags = out_q.header_flags;
	assign res.rem_length = out_q.rem_length;
	assign res.packet_ident = out_q.packet_ident;
	assign res.keepalive_secs = out_q.keepalive_secs;
	assign res.connect_flags = out_q.connect_flags;
	assign res.protocol_level = out_q.protocol_level;
	assign res.connack_code = out_q.connack_code;
	assign res.sess_present = out_q.sess_present;
	assign res.topic_length = out_q.topic_length;
	assign res.filter_count = out_q.filter_count;
endmodule
`default_nettype wire

FILE: sv/mqtt_control_packet_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// MQTT control packet parser: one buffer byte per request, one summary per buffer.
// Throughput is one byte per cycle; the byte-wide phase state machine takes a new byte
// every cycle while the two-entry output buffer has room. The summary is registered in
// that output buffer when the last byte of a buffer is accepted. Asynchronous reset clears
// the phase, the counters, the captured fields and the output buffer.
// Depends on mqcp_pkg, mqcp_in_if, mqcp_out_if and mqcp_skid.
module mqtt_control_packet_parser_top (
	input  wire         clk,
	input  wire         arst_n,
	mqcp_in_if.sink     pkt,
	mqcp_out_if.source  res
);
	import mqcp_pkg::*;

	phase_t      phase_q, n_phase, ph_end;
	logic [28:0] offset_q, n_offset;
	logic [27:0] len_q, n_len, len_grp;
	logic [1:0]  lcnt_q, n_lcnt;
	logic [15:0] left_q, n_left, left_dec;
	logic [7:0]  first_q, n_first;
	logic [15:0] ident_q, n_ident;
	logic [15:0] ka_q, n_ka;
	logic [15:0] cinfo_q, n_cinfo;
	logic [15:0] tlen_q, n_tlen;
	logic [7:0]  fcnt_q, n_fcnt;
	logic [7:0]  b;
	logic        accept;
	logic        space;
	result_t     res_d;

	assign b = pkt.data_byte;
	assign pkt.ready = space;
	assign accept = pkt.valid && space;
	assign left_dec = left_q - 16'd1;

	always_comb begin
		case (lcnt_q)
			2'd0: len_grp = {21'd0, b[6:0]};
			2'd1: len_grp = {14'd0, b[6:0], 7'd0};
			2'd2: len_grp = {7'd0, b[6:0], 14'd0};
			default: len_grp = {b[6:0], 21'd0};
		endcase
	end

	always_comb begin
		n_phase = phase_q;
		n_offset = offset_q;
		n_len = len_q;
		n_lcnt = lcnt_q;
		n_left = left_q;
		n_first = first_q;
		n_ident = ident_q;
		n_ka = ka_q;
		n_cinfo = cinfo_q;
		n_tlen = tlen_q;
		n_fcnt = fcnt_q;
		if (phase_q == PH_FIRST) begin
			n_first = b;
			n_phase = PH_LEN;
		end else if (phase_q == PH_LEN) begin
			n_len = len_q | len_grp;
			if (!b[7] || lcnt_q == LEN_LAST) begin
				n_phase = start_phase(first_q[7:4]);
			end else begin
				n_lcnt = lcnt_q + 2'd1;
			end
		end else begin
			if (offset_q != OFFSET_MAX) begin
				n_offset = offset_q + 29'd1;
			end
			case (phase_q)
				PH_CN_NLHI: begin
					n_left = {b, 8'd0};
					n_phase = PH_CN_NLLO;
				end
				PH_CN_NLLO: begin
					n_left = {left_q[15:8], b};
					n_phase = ({left_q[15:8], b} == 16'd0) ? PH_CN_LEVEL : PH_CN_NAME;
				end
				PH_CN_NAME: begin
					n_left = left_dec;
					if (left_dec == 16'd0) begin
						n_phase = PH_CN_LEVEL;
					end
				end
				PH_CN_LEVEL: begin
					n_cinfo = {b, 8'd0};
					n_phase = PH_CN_FLAGS;
				end
				PH_CN_FLAGS: begin
					n_cinfo = {cinfo_q[15:8], b};
					n_phase = PH_CN_KAHI;
				end
				PH_CN_KAHI: begin
					n_ka = {b, 8'd0};
					n_phase = PH_CN_KALO;
				end
				PH_CN_KALO: begin
					n_ka = {ka_q[15:8], b};
					n_phase = PH_DONE;
				end
				PH_CA_B0: begin
					n_cinfo = {7'd0, b[0], 8'd0};
					n_phase = PH_CA_B1;
				end
				PH_CA_B1: begin
					n_cinfo = {cinfo_q[15:8], b};
					n_phase = PH_DONE;
				end
				PH_PB_TLHI: begin
					n_tlen = {b, 8'd0};
					n_phase = PH_PB_TLLO;
				end
				PH_PB_TLLO: begin
					n_tlen = {tlen_q[15:8], b};
					n_left = {tlen_q[15:8], b};
					n_phase = ({tlen_q[15:8], b} == 16'd0) ? PH_BAD : PH_PB_TOPIC;
				end
				PH_PB_TOPIC: begin
					n_left = left_dec;
					if (left_dec == 16'd0) begin
						n_phase = (first_q[2:1] != 2'd0) ? PH_PB_IDHI : PH_DONE;
					end
				end
				PH_PB_IDHI: begin
					n_ident = {b, 8'd0};
					n_phase = PH_PB_IDLO;
				end
				PH_PB_IDLO: begin
					n_ident = {ident_q[15:8], b};
					n_phase = PH_DONE;
				end
				PH_SB_IDHI: begin
					n_ident = {b, 8'd0};
					n_phase = PH_SB_IDLO;
				end
				PH_SB_IDLO: begin
					n_ident = {ident_q[15:8], b};
					n_phase = PH_SB_FLHI;
				end
				PH_SB_FLHI: begin
					n_left = {b, 8'd0};
					n_phase = PH_SB_FLLO;
				end
				PH_SB_FLLO: begin
					n_left = {left_q[15:8], b};
					n_phase = ({left_q[15:8], b} == 16'd0) ? PH_DONE : PH_SB_FILT;
				end
				PH_SB_FILT: begin
					n_left = left_dec;
					if (left_dec == 16'd0) begin
						if (fcnt_q != COUNT_MAX) begin
							n_fcnt = fcnt_q + 8'd1;
						end
						n_phase = PH_SB_OPTS;
					end
				end
				PH_SB_OPTS: begin
					n_phase = PH_SB_FLHI;
				end
				default: begin
					n_phase = phase_q;
				end
			endcase
		end
	end

	// A buffer that ends while the remaining length is still being read is judged
	// as though the body had started.
	assign ph_end = (n_phase == PH_LEN) ? start_phase(first_q[7:4]) : n_phase;

	always_comb begin
		res_d = '0;
		if (phase_q == PH_FIRST) begin
			res_d.status = ST_MORE;
		end else begin
			res_d.status = ({1'b0, n_len} > n_offset) ? ST_MORE : status_of(ph_end);
			res_d.packet_type = first_q[7:4];
			res_d.header_flags = first_q[3:0];
			res_d.rem_length = n_len;
			if (res_d.status == ST_OK) begin
				case (first_q[7:4])
					TYPE_CONNECT: begin
						res_d.keepalive_secs = n_ka;
						res_d.connect_flags = n_cinfo[7:0];
						res_d.protocol_level = n_cinfo[15:8];
					end
					TYPE_CONNACK: begin
						res_d.connack_code = n_cinfo[7:0];
						res_d.sess_present = n_cinfo[8];
					end
					TYPE_PUBLISH: begin
						res_d.packet_ident = n_ident;
						res_d.topic_length = n_tlen;
					end
					TYPE_SUBSCRIBE: begin
						res_d.packet_ident = n_ident;
						res_d.filter_count = n_fcnt;
					end
					default: begin
						res_d.packet_ident = 16'd0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			offset_q <= '0;
			len_q <= '0;
			lcnt_q <= '0;
			left_q <= '0;
			first_q <= '0;
			ident_q <= '0;
			ka_q <= '0;
			cinfo_q <= '0;
			tlen_q <= '0;
			fcnt_q <= '0;
		end else if (accept) begin
			if (pkt.buffer_end) begin
				phase_q <= PH_FIRST;
				offset_q <= '0;
				len_q <= '0;
				lcnt_q <= '0;
				left_q <= '0;
				first_q <= '0;
				ident_q <= '0;
				ka_q <= '0;
				cinfo_q <= '0;
				tlen_q <= '0;
				fcnt_q <= '0;
			end else begin
				phase_q <= n_phase;
				offset_q <= n_offset;
				len_q <= n_len;
				lcnt_q <= n_lcnt;
				left_q <= n_left;
				first_q <= n_first;
				ident_q <= n_ident;
				ka_q <= n_ka;
				cinfo_q <= n_cinfo;
				tlen_q <= n_tlen;
				fcnt_q <= n_fcnt;
			end
		end
	end

	mqcp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && pkt.buffer_end),
		.push_data (res_d),
		.space     (space),
		.res       (res)
	);
endmodule
`default_nettype wire

FILE: verif/tb_mqtt_control_packet_parser_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for mqtt_control_packet_parser_top: byte buffers of every packet
// type go in, and each summary is checked against an in-bench header parser.
// Depends on mqcp_pkg, mqcp_in_if, mqcp_out_if and the parser RTL.
module tb_mqtt_control_packet_parser_top;
	import mqcp_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int BYTE_TARGET = 1050;
	localparam int TAIL_CYCLES = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       drain;
	} byte_req_t;

	logic clk;
	logic arst_n;

	mqcp_in_if  pkt_if ();
	mqcp_out_if res_if ();

	mqtt_control_packet_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt(pkt_if),
		.res(res_if)
	);

	always #2 clk = ~clk;

	byte_req_t  pending_bytes[$];
	result_t    summary_q[$];
	logic [7:0] body_bytes[$];
	int         mismatches;
	int         idle_cycles;
	int         byte_total;

	phase_t      hp_phase;
	logic [28:0] hp_body_cnt;
	logic [27:0] hp_len;
	logic [1:0]  hp_len_idx;
	logic [15:0] hp_str_left;
	logic [7:0]  hp_hdr;
	logic [15:0] hp_ident;
	logic [15:0] hp_keepalive;
	logic [15:0] hp_conn;
	logic [15:0] hp_topic_len;
	logic [7:0]  hp_filters;

	function automatic phase_t body_entry(input logic [3:0] ptype);
		if (ptype == TYPE_CONNECT)
			return PH_CN_NLHI;
		if (ptype == TYPE_CONNACK)
			return PH_CA_B0;
		if (ptype == TYPE_PUBLISH)
			return PH_PB_TLHI;
		if (ptype == TYPE_SUBSCRIBE)
			return PH_SB_IDHI;
		return PH_DONE;
	endfunction

	function automatic logic [1:0] phase_status(input phase_t ph);
		case (ph)
			PH_BAD, PH_PB_TLHI, PH_PB_TLLO, PH_PB_TOPIC: return ST_BAD;
			PH_CN_NLHI, PH_CN_NLLO, PH_CN_NAME, PH_CN_LEVEL, PH_CN_FLAGS, PH_CN_KAHI,
			PH_CN_KALO, PH_CA_B0, PH_CA_B1, PH_PB_IDHI, PH_PB_IDLO, PH_SB_IDHI,
			PH_SB_IDLO: return ST_MORE;
			default: return ST_OK;
		endcase
	endfunction

	task automatic header_reset();
		hp_phase = PH_FIRST;
		hp_body_cnt = '0;
		hp_len = '0;
		hp_len_idx = '0;
		hp_str_left = '0;
		hp_hdr = '0;
		hp_ident = '0;
		hp_keepalive = '0;
		hp_conn = '0;
		hp_topic_len = '0;
		hp_filters = '0;
	endtask

	task automatic body_advance(input logic [7:0] b);
		if (hp_body_cnt != OFFSET_MAX)
			hp_body_cnt++;
		case (hp_phase)
			PH_CN_NLHI: begin
				hp_str_left = {b, 8'h00};
				hp_phase = PH_CN_NLLO;
			end
			PH_CN_NLLO: begin
				hp_str_left[7:0] = b;
				hp_phase = (hp_str_left == 0) ? PH_CN_LEVEL : PH_CN_NAME;
			end
			PH_CN_NAME: begin
				hp_str_left--;
				if (hp_str_left == 0)
					hp_phase = PH_CN_LEVEL;
			end
			PH_CN_LEVEL: begin
				hp_conn = {b, 8'h00};
				hp_phase = PH_CN_FLAGS;
			end
			PH_CN_FLAGS: begin
				hp_conn[7:0] = b;
				hp_phase = PH_CN_KAHI;
			end
			PH_CN_KAHI: begin
				hp_keepalive = {b, 8'h00};
				hp_phase = PH_CN_KALO;
			end
			PH_CN_KALO: begin
				hp_keepalive[7:0] = b;
				hp_phase = PH_DONE;
			end
			PH_CA_B0: begin
				hp_conn = {7'd0, b[0], 8'h00};
				hp_phase = PH_CA_B1;
			end
			PH_CA_B1: begin
				hp_conn[7:0] = b;
				hp_phase = PH_DONE;
			end
			PH_PB_TLHI: begin
				hp_topic_len = {b, 8'h00};
				hp_phase = PH_PB_TLLO;
			end
			PH_PB_TLLO: begin
				hp_topic_len[7:0] = b;
				hp_str_left = hp_topic_len;
				hp_phase = (hp_topic_len == 0) ? PH_BAD : PH_PB_TOPIC;
			end
			PH_PB_TOPIC: begin
				hp_str_left--;
				if (hp_str_left == 0)
					hp_phase = (hp_hdr[2:1] != 2'd0) ? PH_PB_IDHI : PH_DONE;
			end
			PH_PB_IDHI, PH_SB_IDHI: begin
				hp_ident = {b, 8'h00};
				hp_phase = (hp_phase == PH_PB_IDHI) ? PH_PB_IDLO : PH_SB_IDLO;
			end
			PH_PB_IDLO: begin
				hp_ident[7:0] = b;
				hp_phase = PH_DONE;
			end
			PH_SB_IDLO: begin
				hp_ident[7:0] = b;
				hp_phase = PH_SB_FLHI;
			end
			PH_SB_FLHI: begin
				hp_str_left = {b, 8'h00};
				hp_phase = PH_SB_FLLO;
			end
			PH_SB_FLLO: begin
				hp_str_left[7:0] = b;
				hp_phase = (hp_str_left == 0) ? PH_DONE : PH_SB_FILT;
			end
			PH_SB_FILT: begin
				hp_str_left--;
				if (hp_str_left == 0) begin
					if (hp_filters != COUNT_MAX)
						hp_filters++;
					hp_phase = PH_SB_OPTS;
				end
			end
			PH_SB_OPTS: hp_phase = PH_SB_FLHI;
			default: ;
		endcase
	endtask

	task automatic header_step(input logic [7:0] b, input logic last);
		result_t    r;
		logic [3:0] ptype;
		phase_t     ph;
		r = '0;
		if (hp_phase == PH_FIRST) begin
			hp_hdr = b;
			hp_phase = PH_LEN;
			if (last) begin
				r.status = ST_MORE;
				summary_q.insert(summary_q.size(), r);
				header_reset();
			end
		end else begin
			if (hp_phase == PH_LEN) begin
				hp_len = hp_len | (28'(b[6:0]) << (7 * hp_len_idx));
				if (!b[7] || hp_len_idx == LEN_LAST)
					hp_phase = body_entry(hp_hdr[7:4]);
				else
					hp_len_idx++;
			end else begin
				body_advance(b);
			end
			if (last) begin
				ptype = hp_hdr[7:4];
				ph = (hp_phase == PH_LEN) ? body_entry(ptype) : hp_phase;
				r.status = ({1'b0, hp_len} > hp_body_cnt) ? ST_MORE : phase_status(ph);
				r.packet_type = ptype;
				r.header_flags = hp_hdr[3:0];
				r.rem_length = hp_len;
				if (r.status == ST_OK) begin
					case (ptype)
						TYPE_CONNECT: begin
							r.keepalive_secs = hp_keepalive;
							r.connect_flags = hp_conn[7:0];
							r.protocol_level = hp_conn[15:8];
						end
						TYPE_CONNACK: begin
							r.connack_code = hp_conn[7:0];
							r.sess_present = hp_conn[8];
						end
						TYPE_PUBLISH: begin
							r.packet_ident = hp_ident;
							r.topic_length = hp_topic_len;
						end
						TYPE_SUBSCRIBE: begin
							r.packet_ident = hp_ident;
							r.filter_count = hp_filters;
						end
						default: ;
					endcase
				end
				summary_q.insert(summary_q.size(), r);
				header_reset();
			end
		end
	endtask

	task automatic emit_raw(input logic [7:0] b, input logic last);
		pending_bytes.insert(pending_bytes.size(),
			byte_req_t'{data: b, last: last, drain: 1'b0});
		byte_total++;
	endtask

	task automatic add_drain();
		pending_bytes.insert(pending_bytes.size(),
			byte_req_t'{data: 8'h00, last: 1'b0, drain: 1'b1});
	endtask

	task automatic add_random(input int n);
		repeat (n) body_bytes.insert(body_bytes.size(), 8'($urandom));
	endtask

	task automatic add_field16(input logic [15:0] v);
		body_bytes.insert(body_bytes.size(), v[15:8]);
		body_bytes.insert(body_bytes.size(), v[7:0]);
	endtask

	task automatic add_string(input int len);
		add_field16(16'(len));
		add_random(len);
	endtask

	task automatic emit_buffer(input logic [7:0] hdr, input logic [27:0] claim, input int cut,
		input int extra);
		logic [7:0] frame[$];
		logic [27:0] v;
		logic [7:0] d;
		int n;
		frame.insert(frame.size(), hdr);
		v = claim;
		do begin
			d = {1'b0, v[6:0]};
			v = v >> 7;
			if (v != 0)
				d[7] = 1'b1;
			frame.insert(frame.size(), d);
		end while (v != 0);
		foreach (body_bytes[i])
			frame.insert(frame.size(), body_bytes[i]);
		repeat (extra) frame.insert(frame.size(), 8'($urandom));
		n = frame.size();
		if (cut > 0 && cut < n)
			n = cut;
		for (int i = 0; i < n; i++)
			emit_raw(frame[i], i == n - 1);
		body_bytes.delete();
	endtask

	task automatic gen_packet();
		int kind;
		int n;
		int r;
		int claim;
		int cut;
		int extra;
		logic [3:0] flags;
		logic [7:0] hdr;
		logic [7:0] cf;
		flags = 4'($urandom);
		kind = $urandom_range(0, 9);
		r = $urandom_range(0, 9);
		case (kind)
			0, 1: begin
				hdr = {TYPE_CONNECT, flags};
				n = (r < 7) ? 4 : (r < 9) ? 0 : $urandom_range(7, 65535);
				add_field16(16'(n));
				add_random((n > 6) ? 3 : n);
				body_bytes.insert(body_bytes.size(),
					($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h04);
				cf = 8'($urandom);
				body_bytes.insert(body_bytes.size(), cf);
				add_field16(16'($urandom));
				add_string($urandom_range(0, 4));
				if (cf[2]) begin
					add_string($urandom_range(0, 3));
					add_string($urandom_range(0, 3));
				end
				if (cf[7])
					add_string($urandom_range(0, 3));
				if (cf[6])
					add_string($urandom_range(0, 3));
			end
			2: begin
				hdr = {TYPE_CONNACK, flags};
				add_random(2);
			end
			3, 4, 5: begin
				hdr = {TYPE_PUBLISH, flags};
				n = (r == 0) ? 0 : (r == 1) ? $urandom_range(7, 65535) : $urandom_range(1, 6);
				add_field16(16'(n));
				add_random((n > 6) ? 3 : n);
				if (flags[2:1] != 2'd0)
					add_field16(16'($urandom));
				add_random($urandom_range(0, 5));
			end
			6, 7: begin
				hdr = {TYPE_SUBSCRIBE, flags};
				add_field16(16'($urandom));
				repeat ($urandom_range(0, 4)) begin
					add_string(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4));
					add_random(1);
				end
			end
			8: begin
				hdr = 8'($urandom);
				add_random($urandom_range(0, 5));
			end
			default: begin
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++)
					emit_raw(8'($urandom), i == n - 1);
			end
		endcase
		if (kind != 9) begin
			claim = body_bytes.size();
			r = $urandom_range(0, 11);
			if (r == 0)
				claim += $urandom_range(1, 3);
			else if (r == 1)
				claim = (claim > 3) ? claim - $urandom_range(1, 3) : 0;
			else if (r == 2)
				claim = $urandom_range(0, 28'hFFF_FFFF);
			cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, body_bytes.size() + 6) : 0;
			extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
			emit_buffer(hdr, 28'(claim), cut, extra);
		end
	endtask

	function automatic string describe(input result_t r);
		return $sformatf({"st=%0d type=%0d flags=%h len=%0d id=%h ka=%h cf=%h lvl=%h ",
			"code=%h sp=%0d tl=%0d fc=%0d"}, r.status, r.packet_type, r.header_flags,
			r.rem_length, r.packet_ident, r.keepalive_secs, r.connect_flags,
			r.protocol_level, r.connack_code, r.sess_present, r.topic_length,
			r.filter_count);
	endfunction

	function automatic int field_mismatches(input result_t a, input result_t b);
		int n;
		n = 0;
		n += int'(a.status !== b.status);
		n += int'(a.packet_type !== b.packet_type);
		n += int'(a.header_flags !== b.header_flags);
		n += int'(a.rem_length !== b.rem_length);
		n += int'(a.packet_ident !== b.packet_ident);
		n += int'(a.keepalive_secs !== b.keepalive_secs);
		n += int'(a.connect_flags !== b.connect_flags);
		n += int'(a.protocol_level !== b.protocol_level);
		n += int'(a.connack_code !== b.connack_code);
		n += int'(a.sess_present !== b.sess_present);
		n += int'(a.topic_length !== b.topic_length);
		n += int'(a.filter_count !== b.filter_count);
		return n;
	endfunction

	task automatic check_summary();
		result_t got;
		result_t want;
		got = '{status: res_if.status, packet_type: res_if.packet_type,
			header_flags: res_if.header_flags, rem_length: res_if.rem_length,
			packet_ident: res_if.packet_ident, keepalive_secs: res_if.keepalive_secs,
			connect_flags: res_if.connect_flags, protocol_level: res_if.protocol_level,
			connack_code: res_if.connack_code, sess_present: res_if.sess_present,
			topic_length: res_if.topic_length, filter_count: res_if.filter_count};
		if (summary_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected summary %s", $realtime, describe(got));
		end else begin
			want = summary_q.pop_front();
			if (field_mismatches(want, got) != 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: summary mismatch", $realtime);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		end
	endtask

	int        burst_left;
	int        gap_left;
	logic      load_req;
	byte_req_t next_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_if.valid <= 1'b0;
			pkt_if.data_byte <= 8'h00;
			pkt_if.buffer_end <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (pkt_if.valid && pkt_if.ready)
				header_step(pkt_if.data_byte, pkt_if.buffer_end);
			load_req = 1'b0;
			if (!pkt_if.valid || pkt_if.ready) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_bytes.size() != 0) begin
					if (!pending_bytes[0].drain) begin
						next_req = pending_bytes.pop_front();
						load_req = 1'b1;
						burst_left--;
						if (burst_left == 0) begin
							burst_left = $urandom_range(1, 40);
							gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
						end
					end else if (summary_q.size() == 0) begin
						void'(pending_bytes.pop_front());
					end
				end
				pkt_if.valid <= load_req;
				if (load_req) begin
					pkt_if.data_byte <= next_req.data;
					pkt_if.buffer_end <= next_req.last;
				end
			end
		end
	end

	int   rx_mode;
	int   rx_stall;
	int   rx_cycles;
	logic rx_ready;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			rx_mode = 0;
			rx_stall = 0;
			rx_cycles = 0;
		end else begin
			if (res_if.valid && res_if.ready)
				check_summary();
			rx_cycles++;
			if (rx_cycles % 300 == 0)
				rx_mode = $urandom_range(0, 2);
			case (rx_mode)
				0: rx_ready = 1'b1;
				1: rx_ready = ($urandom_range(0, 3) != 0);
				default: begin
					if (rx_stall != 0) begin
						rx_stall--;
						rx_ready = 1'b0;
					end else if ($urandom_range(0, 5) == 0) begin
						rx_stall = $urandom_range(1, 20);
						rx_ready = 1'b0;
					end else begin
						rx_ready = 1'b1;
					end
				end
			endcase
			res_if.ready <= rx_ready;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		pkt_if.valid = 1'b0;
		pkt_if.data_byte = 8'h00;
		pkt_if.buffer_end = 1'b0;
		res_if.ready = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		byte_total = 0;
		header_reset();

		// A lone header byte, then a four-byte length whose last continuation bit is ignored.
		emit_raw(8'hFF, 1'b1);
		emit_raw(8'hF0, 1'b0);
		repeat (3) emit_raw(8'hFF, 1'b0);
		emit_raw(8'hFF, 1'b1);
		emit_raw(8'h82, 1'b0);
		emit_raw(8'h85, 1'b1);
		emit_buffer(8'h00, 28'd0, 0, 0);
		add_field16(16'h01FF);
		emit_buffer({TYPE_CONNACK, 4'h0}, 28'd2, 0, 0);
		add_field16(16'h0000);
		add_field16(16'hFFC2);
		add_field16(16'hFFFF);
		emit_buffer({TYPE_CONNECT, 4'hF}, 28'd6, 0, 0);
		add_field16(16'h0000);
		emit_buffer({TYPE_PUBLISH, 4'hB}, 28'd2, 0, 0);
		add_drain();

		while (byte_total < BYTE_TARGET) begin
			gen_packet();
			if ($urandom_range(0, 49) == 0)
				add_drain();
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while ((pending_bytes.size() != 0 || pkt_if.valid || summary_q.size() != 0)
			&& idle_cycles < IDLE_LIMIT)
			@(negedge clk);
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** mqtt_control_packet_parser_top: FAILED **");
			$finish;
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			if (mismatches == 0 && summary_q.size() == 0)
				$display("** mqtt_control_packet_parser_top: PASSED **");
			else
				$display("** mqtt_control_packet_parser_top: FAILED **");
			$finish;
		end
	end

endmodule
